// ===== sv/fsml_pkg.sv =====
// ----------------------------------------------------------------------------
// fsml_pkg: shared definitions for the fixed-string match locator
// Register indexes, result kinds, stream constants and parameter defaults.
// ----------------------------------------------------------------------------
package fsml_pkg;

  // parameter defaults
  localparam int MAX_PATTERN_DEF = 8;
  localparam int COUNT_BITS_DEF  = 32;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH = 1'd1;

  // register widths and reset values
  localparam int PAT_BYTES_BITS = 64;
  localparam int PAT_LEN_BITS   = 4;
  localparam logic [PAT_LEN_BITS-1:0] PAT_LEN_RESET = 4'd1;

  // result kinds, carried on out_tuser
  localparam logic KIND_MATCH    = 1'b0;
  localparam logic KIND_NO_MATCH = 1'b1;

  // payload
  localparam int BYTE_BITS   = 8;
  localparam int RESULT_BITS = 32;
  localparam logic [BYTE_BITS-1:0] NEWLINE_BYTE = 8'h0A;

endpackage

// ===== sv/fixed_string_match_locator.sv =====
// ----------------------------------------------------------------------------
// fixed_string_match_locator: stream search for a fixed byte string
// Slides a window over the byte stream and reports every (overlapping) hit.
// ----------------------------------------------------------------------------
// One byte enters per cycle (in_tlast marks the end-of-stream transaction,
// whose data is ignored). The window compare, counter updates and result
// formatting sit between the accepted transaction and a single output
// register, so a result is presented on the cycle after its byte. in_tready
// drops only while the output register holds a result that the downstream
// side is not taking. A match result carries the 1-based start offset in
// out_tdata[31:0] and the line number (newlines up to and including the last
// matched byte, plus one) in out_tdata[63:32]; both saturate at 2^32-1. At
// end of stream a no-match result (offset 0, line 1) is sent if the stream
// had no hit, and the stream counters clear. The user must write the pattern
// registers through the cfg port only while the block is idle (unenforced).
module fixed_string_match_locator
  import fsml_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,   // op: end of stream

  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [63:0]               out_tdata,  // [31:0] match_offset, [63:32] line_number
  output logic                      out_tuser,  // [0] result_kind

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int WIN_BITS = MAX_PATTERN * BYTE_BITS;
  localparam int IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int WIDE     = (COUNT_BITS > RESULT_BITS) ? COUNT_BITS : RESULT_BITS;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [WIDE-1:0]        RESULT_MAX = WIDE'({RESULT_BITS{1'b1}});

  // configuration
  logic [PAT_BYTES_BITS-1:0] pat_bytes_r;
  logic [PAT_LEN_BITS-1:0]   pat_len_r;

  // stream state
  logic [WIN_BITS-1:0]   window_r, window_nxt;
  logic [COUNT_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [COUNT_BITS-1:0] lines_seen_r, lines_seen_nxt;
  logic                  any_match_r, any_match_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [RESULT_BITS-1:0] out_offset_r, out_offset_nxt;
  logic [RESULT_BITS-1:0] out_line_r, out_line_nxt;

  logic                    in_accept;
  logic [PAT_LEN_BITS-1:0] len_eff;
  logic [PAT_LEN_BITS-1:0] len_m1;
  logic [MAX_PATTERN-1:0]  hit_by_len;
  logic                    hit;
  logic                    emit;
  logic [COUNT_BITS-1:0]   offset_cnt;
  logic [WIDE-1:0]         offset_wide;
  logic [WIDE-1:0]         line_wide;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_line_r, out_offset_r};

  // clamp the configured length into 1..MAX_PATTERN
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = PAT_LEN_BITS'(1);
    end else if (pat_len_r > PAT_LEN_BITS'(MAX_PATTERN)) begin
      len_eff = PAT_LEN_BITS'(MAX_PATTERN);
    end else begin
      len_eff = pat_len_r;
    end
    len_m1 = len_eff - PAT_LEN_BITS'(1);
  end

  // shift the new byte in, newest in the low byte
  assign window_nxt = (window_r << BYTE_BITS) | WIN_BITS'(in_tdata);

  // compare the window against the pattern for every candidate length
  always_comb begin
    for (int l = 0; l < MAX_PATTERN; l++) begin
      hit_by_len[l] = 1'b1;
      for (int i = 0; i <= l; i++) begin
        if (pat_bytes_r[i*BYTE_BITS +: BYTE_BITS] != window_nxt[(l-i)*BYTE_BITS +: BYTE_BITS])
        begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    bytes_seen_nxt = (bytes_seen_r == COUNT_MAX) ? COUNT_MAX
                                                 : bytes_seen_r + COUNT_BITS'(1);
    if (in_tdata == NEWLINE_BYTE && lines_seen_r != COUNT_MAX) begin
      lines_seen_nxt = lines_seen_r + COUNT_BITS'(1);
    end else begin
      lines_seen_nxt = lines_seen_r;
    end

    hit = hit_by_len[len_m1[IDX_BITS-1:0]] && (bytes_seen_nxt >= COUNT_BITS'(len_eff));

    offset_cnt  = bytes_seen_nxt - COUNT_BITS'(len_eff) + COUNT_BITS'(1);
    offset_wide = WIDE'(offset_cnt);
    line_wide   = WIDE'(lines_seen_nxt);

    any_match_nxt  = any_match_r;
    emit           = 1'b0;
    out_kind_nxt   = KIND_MATCH;
    out_offset_nxt = (offset_wide > RESULT_MAX) ? {RESULT_BITS{1'b1}}
                                                : offset_wide[RESULT_BITS-1:0];
    out_line_nxt   = (line_wide > RESULT_MAX) ? {RESULT_BITS{1'b1}}
                                              : line_wide[RESULT_BITS-1:0];

    if (in_tlast) begin
      emit           = !any_match_r;
      out_kind_nxt   = KIND_NO_MATCH;
      out_offset_nxt = '0;
      out_line_nxt   = RESULT_BITS'(1);
    end else if (hit) begin
      emit          = 1'b1;
      any_match_nxt = 1'b1;
    end

    // hold the result until taken, load a new one on accept
    if (in_accept) begin
      out_valid_nxt = emit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= PAT_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:  pat_bytes_r <= cfg_data[PAT_BYTES_BITS-1:0];
        CFG_PATTERN_LENGTH: pat_len_r   <= cfg_data[PAT_LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      bytes_seen_r <= '0;
      lines_seen_r <= COUNT_BITS'(1);
      any_match_r  <= 1'b0;
    end else if (in_accept) begin
      if (in_tlast) begin
        // clear for the next stream
        window_r     <= '0;
        bytes_seen_r <= '0;
        lines_seen_r <= COUNT_BITS'(1);
        any_match_r  <= 1'b0;
      end else begin
        window_r     <= window_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        lines_seen_r <= lines_seen_nxt;
        any_match_r  <= any_match_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_kind_r   <= out_kind_nxt;
      out_offset_r <= out_offset_nxt;
      out_line_r   <= out_line_nxt;
    end
  end

endmodule
